/* design/length_crlf_frame_finder_core_macros.svh */
// assertion macros used by the checker of the frame finder
`ifndef LENGTH_CRLF_FRAME_FINDER_CORE_MACROS_SVH
`define LENGTH_CRLF_FRAME_FINDER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define LCFF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define LCFF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/lcff_pkg.sv */
`timescale 1ns / 1ps

package lcff_pkg;

	localparam logic [7:0] CHAR_CR = 8'h0d;
	localparam logic [7:0] CHAR_LF = 8'h0a;

	localparam logic [15:0] MAX_LENGTH_RST    = 16'd1024;
	localparam logic [7:0]  OVERRUN_SLACK_RST = 8'd4;
	localparam logic [15:0] IDLE_LIMIT_RST    = 16'd200;
	localparam logic        BIG_ENDIAN_RST    = 1'b1;

	localparam int CFG_INDEX_W = 2;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_MAX_LENGTH    = 2'd0,
		REG_OVERRUN_SLACK = 2'd1,
		REG_IDLE_LIMIT    = 2'd2,
		REG_BIG_ENDIAN    = 2'd3
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_NONE       = 3'd0,
		ST_DONE       = 3'd1,
		ST_BAD_LENGTH = 3'd2,
		ST_OVERRUN    = 3'd3,
		ST_IDLE       = 3'd4,
		ST_DROPPED    = 3'd5
	} status_t;

	typedef enum logic {
		MODE_DATA = 1'b0,
		MODE_IDLE = 1'b1
	} mode_t;

	typedef struct packed {
		mode_t      mode;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  byte_echo;
		logic [9:0]  byte_position;
		status_t     status;
		logic [10:0] frame_bytes;
	} out_item_t;

endpackage

/* design/length_crlf_frame_finder_core.sv */
`timescale 1ns / 1ps
// channel  direction  handshake             payload
// in       to block   in_valid / in_stall    lcff_pkg::in_item_t
// out      from block out_valid / out_stall  lcff_pkg::out_item_t
// cfg      to block   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one result per item, registered through the input register, then the result register
// a new item is taken every cycle while the result register drains or is empty
// frame state updates in one pass between the input and result registers
// arst_n clears frame state, idle count and the valid flags, and sets the config registers to their defaults
// out_stall holds the result register; in_stall rises while it does and the input register is full
// cfg_ready is always high; writes take effect on the next item

module length_crlf_frame_finder_core #(
	parameter int BUFFER_BYTES = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  lcff_pkg::in_item_t                   in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output lcff_pkg::out_item_t                  out_data,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [lcff_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [15:0]                          cfg_data
);

	localparam int CW   = $clog2(BUFFER_BYTES + 1);
	localparam int CMPW = (CW > 17) ? CW : 17;

	logic [15:0] max_length_q;
	logic [7:0]  overrun_slack_q;
	logic [15:0] idle_limit_q;
	logic        big_endian_q;

	logic [CW-1:0] held_q;
	logic [15:0]   decl_q;
	logic [7:0]    prev_q;
	logic [15:0]   idle_q;

	logic               valid_s1;
	lcff_pkg::in_item_t item_s1;
	logic               out_valid_q;
	lcff_pkg::out_item_t res_q;

	logic advance;

	// next-state and result, from the item in the input register
	logic [CW-1:0]       held_d;
	logic [15:0]         decl_d;
	logic [7:0]          prev_d;
	logic [15:0]         idle_d;
	lcff_pkg::out_item_t res_d;

	logic [CW-1:0]   held_inc;
	logic [15:0]     decl_new;
	logic [CMPW-1:0] held_ext;
	logic [CMPW-1:0] held_inc_ext;
	logic [CMPW-1:0] decl_ext;
	logic [CMPW-1:0] limit_ext;
	logic [7:0]      b;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign out_valid = out_valid_q;
	assign out_data  = res_q;

	assign b            = item_s1.data_byte;
	assign held_inc     = held_q + CW'(1);
	assign held_ext     = CMPW'(held_q);
	assign held_inc_ext = CMPW'(held_inc);

	always_comb begin
		if (held_q == '0) begin
			decl_new = big_endian_q ? {b, 8'h00} : {8'h00, b};
		end else if (held_q == CW'(1)) begin
			decl_new = decl_q | (big_endian_q ? {8'h00, b} : {b, 8'h00});
		end else begin
			decl_new = decl_q;
		end
	end

	assign decl_ext  = CMPW'(decl_new);
	assign limit_ext = CMPW'(decl_new) + CMPW'(overrun_slack_q);

	always_comb begin
		held_d = held_q;
		decl_d = decl_q;
		prev_d = prev_q;
		idle_d = idle_q;
		res_d  = '{byte_echo: 8'h00, byte_position: 10'd0,
			status: lcff_pkg::ST_NONE, frame_bytes: 11'd0};
		if (item_s1.mode == lcff_pkg::MODE_IDLE) begin
			if (idle_q >= idle_limit_q) begin
				idle_d = '0;
				held_d = '0;
				decl_d = '0;
				prev_d = '0;
				res_d.status      = lcff_pkg::ST_IDLE;
				res_d.frame_bytes = held_ext[10:0];
			end else begin
				idle_d = idle_q + 16'd1;
			end
		end else begin
			idle_d          = '0;
			res_d.byte_echo = b;
			if (held_ext >= CMPW'(BUFFER_BYTES)) begin
				res_d.status = lcff_pkg::ST_DROPPED;
			end else begin
				res_d.byte_position = held_ext[9:0];
				held_d = held_inc;
				decl_d = decl_new;
				prev_d = b;
				// checks start once two bytes are held
				if (held_q != '0) begin
					if (decl_new >= max_length_q) begin
						res_d.status = lcff_pkg::ST_BAD_LENGTH;
					end else if (prev_q == lcff_pkg::CHAR_CR && b == lcff_pkg::CHAR_LF
						&& held_inc_ext >= decl_ext) begin
						res_d.status = lcff_pkg::ST_DONE;
					end else if (held_inc_ext > limit_ext) begin
						res_d.status = lcff_pkg::ST_OVERRUN;
					end
					if (res_d.status != lcff_pkg::ST_NONE) begin
						res_d.frame_bytes = held_inc_ext[10:0];
						held_d = '0;
						decl_d = '0;
						prev_d = '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q    <= lcff_pkg::MAX_LENGTH_RST;
			overrun_slack_q <= lcff_pkg::OVERRUN_SLACK_RST;
			idle_limit_q    <= lcff_pkg::IDLE_LIMIT_RST;
			big_endian_q    <= lcff_pkg::BIG_ENDIAN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (lcff_pkg::reg_index_t'(cfg_index))
				lcff_pkg::REG_MAX_LENGTH:    max_length_q    <= cfg_data;
				lcff_pkg::REG_OVERRUN_SLACK: overrun_slack_q <= cfg_data[7:0];
				lcff_pkg::REG_IDLE_LIMIT:    idle_limit_q    <= cfg_data;
				lcff_pkg::REG_BIG_ENDIAN:    big_endian_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			held_q      <= '0;
			decl_q      <= '0;
			prev_q      <= '0;
			idle_q      <= '0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				held_q      <= held_d;
				decl_q      <= decl_d;
				prev_q      <= prev_d;
				idle_q      <= idle_d;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
		if (advance) begin
			res_q <= res_d;
		end
	end

endmodule

/* design/lcff_checker.sv */
`timescale 1ns / 1ps
`include "length_crlf_frame_finder_core_macros.svh"

module lcff_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_stall,
	input lcff_pkg::out_item_t out_data
);

	// a stalled result stays put
	`LCFF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result changed under stall")

	// only frame-ending results (done, bad length, overrun, idle clear) report a byte count
	`LCFF_ASSERT_NOW(a_count_zero, out_valid && (out_data.status == lcff_pkg::ST_NONE || out_data.status == lcff_pkg::ST_DROPPED), out_data.frame_bytes == 11'd0, "byte count on a plain or dropped byte")

	// dropped bytes carry no position
	`LCFF_ASSERT_NOW(a_drop_pos, out_valid && out_data.status == lcff_pkg::ST_DROPPED, out_data.byte_position == 10'd0, "position on a dropped byte")

	// idle clear is not tied to a byte
	`LCFF_ASSERT_NOW(a_idle_clear, out_valid && out_data.status == lcff_pkg::ST_IDLE, out_data.byte_echo == 8'h00 && out_data.byte_position == 10'd0, "byte fields on an idle clear")

endmodule

bind length_crlf_frame_finder_core lcff_checker u_lcff_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
